### hw/rtl/fatw_pkg.sv
// Shared types, constants and helpers for the FAT12 cluster chain walker.
package fatw_pkg;

    // Default size of the FAT byte store.
    localparam int FAT_BYTES_DEF = 8192;

    // Largest FAT byte index a 12-bit cluster can produce: 0xFFF + 0x7FF.
    localparam int IDX_MAX = 6142;

    // Field widths.
    localparam int CLUSTER_W = 12;
    localparam int COUNT_W   = 20;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    // Chain markers and saturation limit.
    localparam logic [CLUSTER_W-1:0] CHAIN_END_MIN = 12'hFF8;
    localparam logic [CLUSTER_W-1:0] ENTRY_MASK    = 12'hFFF;
    localparam logic [COUNT_W-1:0]   COUNT_MAX     = 20'hFFFFF;

    // Register reset values.
    localparam logic [12:0] BPS_RST  = 13'd512;
    localparam logic [7:0]  SPC_RST  = 8'd1;
    localparam logic [15:0] RSV_RST  = 16'd1;
    localparam logic [15:0] SPF_RST  = 16'd9;
    localparam logic [2:0]  FATC_RST = 3'd2;
    localparam logic [15:0] ROOT_RST = 16'd224;

    // Data-area divider: root directory bytes plus rounding over sector size.
    localparam int DVD_W     = 22;
    localparam int DSR_W     = 13;
    localparam int DIV_STEPS = DVD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Input word kinds.
    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_START = 2'd1,
        KIND_STEP  = 2'd2
    } kind_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BPS  = 3'd0,
        CFG_SPC  = 3'd1,
        CFG_RSV  = 3'd2,
        CFG_SPF  = 3'd3,
        CFG_FATC = 3'd4,
        CFG_ROOT = 3'd5
    } cfg_idx_t;

    // Walker control states.
    typedef enum logic {
        ST_IDLE,
        ST_STEP
    } walk_state_t;

    // Divider status seen by the top level.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // A cluster value that ends (or never starts) a chain.
    function automatic logic ends_chain(input logic [CLUSTER_W-1:0] c);
        ends_chain = (c < 12'd2) || (c >= CHAIN_END_MIN);
    endfunction

endpackage

### hw/rtl/fatw_ram.sv
// Generic single-write, dual-read synchronous RAM with registered read data.
module fatw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and two registered read ports.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

### hw/rtl/fatw_div.sv
// Iterative restoring divider for the root directory sector count.
module fatw_div
    import fatw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output div_status_t      status,
    output logic [DVD_W-1:0] quotient
);

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0]     quot_reg;
    logic [DSR_W-1:0]     rem_reg;
    logic [DSR_W-1:0]     dsr_reg;

    logic [DSR_W:0]       trial;
    logic                 qbit;
    logic [DSR_W-1:0]     rem_next;
    logic [DVD_W-1:0]     quot_next;

    // One quotient bit per cycle: shift in the next dividend bit and try a subtract.
    always_comb
    begin
        trial     = {rem_reg, quot_reg[DVD_W-1]};
        qbit      = (trial >= {1'b0, dsr_reg});
        rem_next  = qbit ? DSR_W'(trial - {1'b0, dsr_reg}) : DSR_W'(trial);
        quot_next = {quot_reg[DVD_W-2:0], qbit};
    end

    assign status.busy = busy_reg;
    assign status.done = busy_reg && (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign quotient    = quot_next;

    // Control: a start always restarts the division from scratch.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            busy_reg <= !status.done;
            cnt_reg  <= cnt_reg + DIV_CNT_W'(1);
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dsr_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

endmodule

### hw/rtl/fat12_cluster_chain_walker.sv
// FAT12 cluster chain walker top level: FAT store, chain state and result register.
//
// Load words write one byte of the FAT copy held in an on-chip RAM; start words set
// the first cluster and file size; each step word on a running chain returns the
// current cluster, the LBA of its first sector and the file bytes it holds, then
// follows the chain. A step word first lets the dual-port FAT RAM return both bytes
// of the 12-bit entry, then forms the next cluster and writes the result register,
// which frees the input side while a result waits. The data-area start is formed
// by a bit-serial divider (root directory bytes over sector size, rounded up);
// after reset and after every write to a defined register index the input is held
// off while it runs. A step that finds the result register still full waits there
// until it drains.
module fat12_cluster_chain_walker
    import fatw_pkg::*;
#(
    parameter int FAT_BYTES = FAT_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // Input channel.
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           kind,
    input  logic [12:0]          fat_address,
    input  logic [7:0]           fat_byte,
    input  logic [CLUSTER_W-1:0] first_cluster,
    input  logic [31:0]          file_size,
    // Result channel.
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [CLUSTER_W-1:0] cluster,
    output logic [31:0]          sector_lba,
    output logic [COUNT_W-1:0]   byte_count,
    output logic                 last,
    // Configuration port.
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int AW   = $clog2(FAT_BYTES);
    localparam int MAXQ = IDX_MAX / FAT_BYTES;

    // Configuration registers.
    logic [12:0] bps_reg;
    logic [7:0]  spc_reg;
    logic [15:0] rsv_reg;
    logic [15:0] spf_reg;
    logic [2:0]  fatc_reg;
    logic [15:0] root_reg;
    logic        pending_reg;

    // Derived values.
    logic [19:0]        base_reg;
    logic [20:0]        per_cluster_reg;
    logic [31:0]        shadow_reg;
    logic [DVD_W-1:0]   dividend;
    logic [DVD_W-1:0]   quotient;
    div_status_t        div_status;

    // Chain state.
    walk_state_t          state_reg, state_next;
    logic                 active_reg, active_next;
    logic [CLUSTER_W-1:0] cluster_reg, cluster_next;
    logic [31:0]          remain_reg, remain_next;
    logic [31:0]          data_start_reg, data_start_next;

    // Result register.
    logic                 out_valid_reg, out_valid_next;
    logic [CLUSTER_W-1:0] out_cluster_reg, out_cluster_next;
    logic [31:0]          out_lba_reg, out_lba_next;
    logic [COUNT_W-1:0]   out_count_reg, out_count_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_load;

    // FAT access.
    logic [12:0]          idx_full;
    logic [13:0]          idx_red;
    logic [AW-1:0]        idx0;
    logic [AW-1:0]        idx1;
    logic [7:0]           rd_lo;
    logic [7:0]           rd_hi;
    logic [15:0]          fat_word;
    logic [CLUSTER_W-1:0] next_cluster;
    logic                 next_last;
    logic                 in_fire;
    logic                 fat_we;

    // Step arithmetic.
    logic [31:0]        count_a;
    logic [COUNT_W-1:0] count;
    logic [19:0]        offset;
    logic [31:0]        lba;

    assign in_fire  = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE) && !pending_reg && !div_status.busy;

    // Configuration writes; any valid write schedules a data-area recompute.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bps_reg     <= BPS_RST;
            spc_reg     <= SPC_RST;
            rsv_reg     <= RSV_RST;
            spf_reg     <= SPF_RST;
            fatc_reg    <= FATC_RST;
            root_reg    <= ROOT_RST;
            pending_reg <= 1'b1;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_BPS:
                    begin
                        bps_reg     <= cfg_data[12:0];
                        pending_reg <= 1'b1;
                    end
                    CFG_SPC:
                    begin
                        spc_reg     <= cfg_data[7:0];
                        pending_reg <= 1'b1;
                    end
                    CFG_RSV:
                    begin
                        rsv_reg     <= cfg_data;
                        pending_reg <= 1'b1;
                    end
                    CFG_SPF:
                    begin
                        spf_reg     <= cfg_data;
                        pending_reg <= 1'b1;
                    end
                    CFG_FATC:
                    begin
                        fatc_reg    <= cfg_data[2:0];
                        pending_reg <= 1'b1;
                    end
                    CFG_ROOT:
                    begin
                        root_reg    <= cfg_data;
                        pending_reg <= 1'b1;
                    end
                    default:
                    begin
                        pending_reg <= 1'b0;
                    end
                endcase
            end
            else
            begin
                pending_reg <= 1'b0;
            end
        end
    end

    // Root directory bytes rounded up to whole sectors feed the divider.
    assign dividend = DVD_W'({root_reg, 5'b0}) + DVD_W'(bps_reg) - DVD_W'(1);

    fatw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (pending_reg),
        .dividend (dividend),
        .divisor  (bps_reg),
        .status   (div_status),
        .quotient (quotient)
    );

    // Registered derived values; the data-area start loads when the divider is done.
    always_ff @(posedge clk)
    begin
        base_reg        <= 20'(rsv_reg) + 20'(fatc_reg) * 20'(spf_reg);
        per_cluster_reg <= 21'(spc_reg) * 21'(bps_reg);
        if (div_status.done)
        begin
            shadow_reg <= 32'(base_reg)
                        + ((bps_reg == '0) ? 32'd0 : 32'(quotient));
        end
    end

    // FAT byte index of the entry for the current cluster, wrapped into the store.
    always_comb
    begin
        idx_full = {1'b0, cluster_reg} + {2'b0, cluster_reg[CLUSTER_W-1:1]};
        idx_red  = {1'b0, idx_full};
        for (int k = 0; k <= MAXQ; k++)
        begin
            if ({1'b0, idx_full} >= 14'(k * FAT_BYTES))
            begin
                idx_red = {1'b0, idx_full} - 14'(k * FAT_BYTES);
            end
        end
        idx0 = idx_red[AW-1:0];
        idx1 = (idx0 == AW'(FAT_BYTES - 1)) ? '0 : idx0 + AW'(1);
    end

    assign fat_we = in_fire && (kind == KIND_LOAD)
                 && ({1'b0, fat_address} < 14'(FAT_BYTES));

    fatw_ram #(
        .WIDTH (8),
        .DEPTH (FAT_BYTES)
    ) u_fat (
        .clk     (clk),
        .we      (fat_we),
        .waddr   (fat_address[AW-1:0]),
        .wdata   (fat_byte),
        .raddr_a (idx0),
        .rdata_a (rd_lo),
        .raddr_b (idx1),
        .rdata_b (rd_hi)
    );

    // Next entry decode and the figures for the cluster being reported.
    always_comb
    begin
        fat_word     = {rd_hi, rd_lo};
        next_cluster = cluster_reg[0] ? fat_word[15:4] : (fat_word[11:0] & ENTRY_MASK);
        next_last    = ends_chain(next_cluster);
        count_a      = (remain_reg > 32'(per_cluster_reg)) ? 32'(per_cluster_reg)
                                                            : remain_reg;
        count        = (count_a > 32'(COUNT_MAX)) ? COUNT_MAX : count_a[COUNT_W-1:0];
        offset       = 20'(cluster_reg - 12'd2) * 20'(spc_reg);
        lba          = data_start_reg + 32'(offset);
    end

    // Next state and result register.
    always_comb
    begin
        state_next       = state_reg;
        active_next      = active_reg;
        cluster_next     = cluster_reg;
        remain_next      = remain_reg;
        data_start_next  = data_start_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_cluster_next = out_cluster_reg;
        out_lba_next     = out_lba_reg;
        out_count_next   = out_count_reg;
        out_last_next    = out_last_reg;
        out_load         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (kind_t'(kind))
                        KIND_START:
                        begin
                            data_start_next = shadow_reg;
                            cluster_next    = first_cluster;
                            remain_next     = file_size;
                            active_next     = !ends_chain(first_cluster);
                        end
                        KIND_STEP:
                        begin
                            if (active_reg)
                            begin
                                state_next = ST_STEP;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_STEP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load         = 1'b1;
                    out_valid_next   = 1'b1;
                    out_cluster_next = cluster_reg;
                    out_lba_next     = lba;
                    out_count_next   = count;
                    out_last_next    = next_last;
                    remain_next      = remain_reg - 32'(count);
                    if (next_last)
                    begin
                        active_next = 1'b0;
                    end
                    else
                    begin
                        cluster_next = next_cluster;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and chain state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            active_reg     <= 1'b0;
            cluster_reg    <= '0;
            remain_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            cluster_reg    <= cluster_next;
            remain_reg     <= remain_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        data_start_reg <= data_start_next;
        if (out_load)
        begin
            out_cluster_reg <= out_cluster_next;
            out_lba_reg     <= out_lba_next;
            out_count_reg   <= out_count_next;
            out_last_reg    <= out_last_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cluster    = out_cluster_reg;
    assign sector_lba = out_lba_reg;
    assign byte_count = out_count_reg;
    assign last       = out_last_reg;

endmodule

### test/fat12_cluster_chain_walker_tb.sv
// Self-checking testbench for the FAT12 cluster chain walker: stimulus, prediction and checks.
module fat12_cluster_chain_walker_tb;
    import fatw_pkg::*;

    localparam int FAT_SIZE = FAT_BYTES_DEF;
    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 30;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_REPORTS = 10;

    // One visited cluster as the block reports it.
    typedef struct packed {
        logic [CLUSTER_W-1:0] cluster;
        logic [31:0]          lba;
        logic [COUNT_W-1:0]   count;
        logic                 last;
    } visit_t;

    // Shadow of the walker: registers, FAT copy, chain state and the visits still owed.
    class walk_tracker;
        logic [12:0] bps;
        logic [7:0]  spc;
        logic [15:0] rsv;
        logic [15:0] spf;
        logic [2:0]  fatc;
        logic [15:0] root;
        logic [7:0]  fat [FAT_SIZE];
        bit          written [FAT_SIZE];
        logic [CLUSTER_W-1:0] cur;
        logic [31:0] remaining;
        bit          walking;
        logic [31:0] area_start;
        visit_t      pending [$];
        int mismatches;
        int checked;
        int lasts;
        int starts;
        int useful;

        function new();
            bps = BPS_RST;
            spc = SPC_RST;
            rsv = RSV_RST;
            spf = SPF_RST;
            fatc = FATC_RST;
            root = ROOT_RST;
            cur = '0;
            remaining = '0;
            walking = 0;
            mismatches = 0;
            checked = 0;
            lasts = 0;
            starts = 0;
            useful = 0;
            refresh_area();
        endfunction

        // Reserved area, all FAT copies and the root directory rounded up to whole sectors.
        function void refresh_area();
            logic [31:0] root_bytes;
            logic [31:0] root_secs;
            logic [31:0] fat_secs;
            root_bytes = root;
            root_bytes = root_bytes * 32;
            root_secs = 0;
            if (bps != 0)
                root_secs = (root_bytes + bps - 1) / bps;
            fat_secs = fatc;
            fat_secs = fat_secs * spf;
            area_start = rsv + fat_secs + root_secs;
        endfunction

        function bit chain_over(logic [CLUSTER_W-1:0] c);
            return (c < 2) || (c >= CHAIN_END_MIN);
        endfunction

        function int entry_index(logic [CLUSTER_W-1:0] c);
            int i;
            i = c;
            return i + (i >> 1);
        endfunction

        function bit entry_known(logic [CLUSTER_W-1:0] c);
            int i;
            i = entry_index(c);
            return written[i % FAT_SIZE] && written[(i + 1) % FAT_SIZE];
        endfunction

        // Little-endian word at the entry's byte; odd clusters take the upper 12 bits.
        function logic [CLUSTER_W-1:0] entry_of(logic [CLUSTER_W-1:0] c);
            int i;
            logic [15:0] w;
            i = entry_index(c);
            w = {fat[(i + 1) % FAT_SIZE], fat[i % FAT_SIZE]};
            return c[0] ? w[15:4] : w[11:0];
        endfunction

        // A register write only moves the data-area start while no chain is running.
        function void write_reg(cfg_idx_t idx, logic [CFG_W-1:0] v);
            case (idx)
                CFG_BPS:  bps = v[12:0];
                CFG_SPC:  spc = v[7:0];
                CFG_RSV:  rsv = v;
                CFG_SPF:  spf = v;
                CFG_FATC: fatc = v[2:0];
                CFG_ROOT: root = v;
                default: ;
            endcase
            if (!walking)
                refresh_area();
        endfunction

        // Apply one accepted input word and queue the visit it causes, if any.
        function void note_word(logic [1:0] k, logic [12:0] addr, logic [7:0] value,
                                logic [CLUSTER_W-1:0] first, logic [31:0] file_len);
            logic [31:0] per;
            logic [31:0] count;
            logic [31:0] c32;
            logic [CLUSTER_W-1:0] link;
            visit_t v;
            case (k)
                KIND_LOAD:
                begin
                    if (addr < FAT_SIZE)
                    begin
                        fat[addr] = value;
                        written[addr] = 1;
                    end
                    useful++;
                end
                KIND_START:
                begin
                    refresh_area();
                    cur = first;
                    remaining = file_len;
                    walking = !chain_over(first);
                    starts++;
                    useful++;
                end
                KIND_STEP:
                if (walking)
                begin
                    per = spc;
                    per = per * bps;
                    count = remaining;
                    if (count > per)
                        count = per;
                    if (count > COUNT_MAX)
                        count = COUNT_MAX;
                    remaining = remaining - count;
                    link = entry_of(cur);
                    c32 = cur;
                    v.cluster = cur;
                    v.lba = area_start + (c32 - 2) * spc;
                    v.count = count[COUNT_W-1:0];
                    v.last = chain_over(link);
                    pending.push_back(v);
                    useful++;
                    if (v.last)
                    begin
                        walking = 0;
                        refresh_area();
                        lasts++;
                    end
                    else
                        cur = link;
                end
                default: ;
            endcase
        endfunction

        // Compare one accepted visit with the oldest one owed.
        function void check_visit(visit_t got);
            visit_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected visit: cluster %h lba %h count %h last %b",
                             got.cluster, got.lba, got.count, got.last);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("visit %0d wrong (expected/actual): cluster %h/%h lba %h/%h count %h/%h last %b/%b",
                             checked, want.cluster, got.cluster, want.lba, got.lba,
                             want.count, got.count, want.last, got.last);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           kind;
    logic [12:0]          fat_address;
    logic [7:0]           fat_byte;
    logic [CLUSTER_W-1:0] first_cluster;
    logic [31:0]          file_size;
    logic                 out_valid;
    logic                 out_ready;
    logic [CLUSTER_W-1:0] cluster;
    logic [31:0]          sector_lba;
    logic [COUNT_W-1:0]   byte_count;
    logic                 last;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    walk_tracker tracker = new();
    bit steady = 0;
    int settings_used = 1;
    int cycles = 0;

    fat12_cluster_chain_walker dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .kind(kind),
        .fat_address(fat_address),
        .fat_byte(fat_byte),
        .first_cluster(first_cluster),
        .file_size(file_size),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .cluster(cluster),
        .sector_lba(sector_lba),
        .byte_count(byte_count),
        .last(last),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Clock with a 12-unit period.
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Offer one word, with random idle cycles ahead of it outside steady runs, and note it once accepted.
    task automatic send_word(logic [1:0] k, logic [12:0] addr, logic [7:0] value,
                             logic [CLUSTER_W-1:0] first, logic [31:0] file_len);
        if (!steady)
            while ($urandom_range(99) < 26)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid <= 1'b1;
        kind <= k;
        fat_address <= addr;
        fat_byte <= value;
        first_cluster <= first;
        file_size <= file_len;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.note_word(k, addr, value, first, file_len);
    endtask

    // Write a 12-bit FAT entry with two byte loads, keeping the neighbor's nibble.
    task automatic set_entry(logic [CLUSTER_W-1:0] c, logic [CLUSTER_W-1:0] v);
        int i;
        logic [7:0] lo;
        logic [7:0] hi;
        i = tracker.entry_index(c);
        lo = tracker.written[i] ? tracker.fat[i] : $urandom_range(255);
        hi = tracker.written[i + 1] ? tracker.fat[i + 1] : $urandom_range(255);
        if (c[0])
        begin
            lo = {v[3:0], lo[3:0]};
            hi = v[11:4];
        end
        else
        begin
            lo = v[7:0];
            hi = {hi[7:4], v[11:8]};
        end
        send_word(KIND_LOAD, i, lo, $urandom_range(4095), $urandom);
        send_word(KIND_LOAD, i + 1, hi, $urandom_range(4095), $urandom);
    endtask

    function automatic logic [CLUSTER_W-1:0] end_mark();
        int r;
        r = $urandom_range(9);
        if (r < 2)
            return r;
        return CHAIN_END_MIN + (r - 2);
    endfunction

    task automatic start_word(logic [CLUSTER_W-1:0] first, logic [31:0] file_len);
        send_word(KIND_START, $urandom_range(8191), $urandom_range(255), first, file_len);
    endtask

    // A step never reads an entry that was never loaded: load it first if needed.
    task automatic step_word();
        if (tracker.walking && !tracker.entry_known(tracker.cur))
            set_entry(tracker.cur, $urandom_range(1) ? end_mark()
                                                     : $urandom_range(2, CHAIN_END_MIN - 1));
        send_word(KIND_STEP, $urandom_range(8191), $urandom_range(255),
                  $urandom_range(4095), $urandom);
    endtask

    // Lay down a short chain, start a file on it and walk it.
    task automatic walk_chain();
        logic [CLUSTER_W-1:0] links [8];
        int len;
        int n;
        int base;
        logic [31:0] per;
        logic [31:0] file_len;
        len = $urandom_range(1, 6);
        if ($urandom_range(1))
        begin
            base = $urandom_range(2, CHAIN_END_MIN - 1 - len);
            for (int k = 0; k < len; k++)
                links[k] = base + k;
        end
        else
            for (int k = 0; k < len; k++)
                links[k] = $urandom_range(2, CHAIN_END_MIN - 1);
        for (int k = 0; k < len; k++)
            set_entry(links[k], (k == len - 1) ? end_mark() : links[k + 1]);
        per = tracker.spc;
        per = per * tracker.bps;
        if (per > COUNT_MAX)
            per = COUNT_MAX;
        case ($urandom_range(3))
            0: file_len = $urandom_range(0, per * len + per);
            1: file_len = per * len;
            2: file_len = $urandom;
            default: file_len = $urandom_range(3);
        endcase
        start_word(links[0], file_len);
        n = len;
        if ($urandom_range(9) == 0)
            n = $urandom_range(len);
        else if ($urandom_range(9) == 0)
            n = len + 1;
        repeat (n)
            step_word();
    endtask

    // Mostly well-formed chains, with stray loads, starts, steps and unknown words mixed in.
    task automatic run_phase(int budget);
        int goal;
        int roll;
        goal = tracker.useful + budget;
        while (tracker.useful < goal)
        begin
            roll = $urandom_range(99);
            if (roll < 65)
                walk_chain();
            else if (roll < 78)
                send_word(KIND_LOAD, $urandom_range(8191), $urandom_range(255),
                          $urandom_range(4095), $urandom);
            else if (roll < 86)
                start_word($urandom_range(4095), $urandom);
            else if (roll < 92)
                send_word(KIND_NONE, $urandom_range(8191), $urandom_range(255),
                          $urandom_range(4095), $urandom);
            else
                step_word();
        end
    endtask

    // Stop sending and wait until every visit has arrived and the block is quiet.
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_one(cfg_idx_t idx, logic [CFG_W-1:0] v);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        tracker.write_reg(idx, v);
    endtask

    task automatic write_regs(logic [CFG_W-1:0] bps_v, logic [CFG_W-1:0] spc_v,
                              logic [CFG_W-1:0] rsv_v, logic [CFG_W-1:0] spf_v,
                              logic [CFG_W-1:0] fatc_v, logic [CFG_W-1:0] root_v);
        write_one(CFG_BPS, bps_v);
        write_one(CFG_SPC, spc_v);
        write_one(CFG_RSV, rsv_v);
        write_one(CFG_SPF, spf_v);
        write_one(CFG_FATC, fatc_v);
        write_one(CFG_ROOT, root_v);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    // Short directed walk over the corner cases at reset settings.
    task automatic directed();
        // Step with no chain, then a word of unknown kind with every bit set.
        step_word();
        send_word(KIND_NONE, 13'h1FFF, 8'hFF, 12'hFFF, 32'hFFFF_FFFF);
        // Two-cluster chain over an even and an odd entry, largest file size.
        set_entry(12'd2, 12'd3);
        set_entry(12'd3, 12'hFFF);
        start_word(12'd2, 32'hFFFF_FFFF);
        step_word();
        step_word();
        // Starts that never open a chain, and a step after them.
        start_word(12'd0, 32'd100);
        start_word(12'd1, 32'd100);
        start_word(CHAIN_END_MIN, 32'd100);
        start_word(12'hFFF, 32'd100);
        step_word();
        // Highest ordinary cluster, empty file, chain ended by a free entry.
        set_entry(CHAIN_END_MIN - 1, 12'd0);
        start_word(CHAIN_END_MIN - 1, 32'd0);
        step_word();
        // Restart in the middle of a walk; the chain then ends on the lowest end marker.
        set_entry(12'd3, CHAIN_END_MIN);
        start_word(12'd2, 32'd700);
        step_word();
        start_word(12'd3, 32'd100);
        step_word();
    endtask

    // Result side: check each accepted word, stall at random, and hold off once for long.
    initial
    begin
        int hold_left;
        bit held;
        visit_t got;
        hold_left = 0;
        held = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got = {cluster, sector_lba, byte_count, last};
                tracker.check_visit(got);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!held && tracker.checked >= 120)
            begin
                held = 1;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else
                out_ready <= steady || ($urandom_range(99) >= 26);
        end
    end

    // Cycle limit.
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles with %0d visits outstanding",
                 cycles, tracker.pending.size());
        $display("status: fail");
        $finish;
    end

    // Main sequence: reset, directed words, then random phases over several settings.
    initial
    begin
        int errors;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        kind <= KIND_LOAD;
        fat_address <= '0;
        fat_byte <= '0;
        first_cluster <= '0;
        file_size <= '0;
        cfg_write <= 1'b0;
        cfg_index <= CFG_BPS;
        cfg_data <= '0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed();
        run_phase(240);

        settle();
        write_regs(16'd1, 16'd1, 16'd0, 16'd0, 16'd1, 16'd0);
        run_phase(240);

        // Largest legal geometry, run with no idling on either side.
        settle();
        write_regs(16'd4096, 16'd128, 16'hFFFF, 16'hFFFF, 16'd4, 16'hFFFF);
        steady = 1;
        run_phase(240);
        steady = 0;

        // Zero sector size: no root sectors and empty clusters.
        settle();
        write_regs(16'd0, 16'd7, 16'd3, 16'd100, 16'd2, 16'd512);
        run_phase(150);

        // Widest sector size, sectors per cluster and FAT count: cluster size beyond the count limit.
        settle();
        write_regs(16'd8191, 16'd255, 16'd1234, 16'hFFFF, 16'd7, 16'hFFFF);
        run_phase(200);

        settle();
        write_regs(16'd512, 16'd0, 16'd32, 16'd9, 16'd0, 16'd16);
        run_phase(150);

        settle();
        write_regs($urandom_range(1, 4096), $urandom_range(1, 128), $urandom_range(65535),
                   $urandom_range(65535), $urandom_range(1, 4), $urandom_range(65535));
        run_phase(240);

        settle();
        write_regs($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                   $urandom_range(65535), $urandom_range(65535), $urandom_range(65535));
        run_phase(240);

        settle();
        errors = tracker.mismatches + tracker.pending.size();
        if (tracker.pending.size() != 0)
            $display("%0d expected visits never arrived", tracker.pending.size());
        $display("covered %0d words, %0d chain starts, %0d visits (%0d chain ends), %0d settings",
                 tracker.useful, tracker.starts, tracker.checked, tracker.lasts, settings_used);
        $display("%0d mismatches in %0d cycles", tracker.mismatches, cycles);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
